[sv/rrd_pkg.sv]
`default_nettype none
package rrd_pkg;

  localparam int CompW  = 16;
  localparam int OutW   = 22;
  localparam int PW     = 26;
  localparam int DiffW  = 50;
  localparam int RootW  = DiffW / 2;
  localparam int FrontStages = 9;

  localparam logic signed [33:0] OneQ28 = 34'sd268435456;
  localparam logic signed [31:0] OutMax = 32'sd2097151;
  localparam logic signed [31:0] OutMin = -32'sd2097152;

  typedef logic [2:0][CompW-1:0] vec_t;
  typedef logic [2:0][PW-1:0]    pvec_t;

  // Data that rides alongside the square root pipeline.
  typedef struct packed {
    vec_t  n;
    pvec_t p;
  } carry_t;

endpackage
`default_nettype wire

[sv/rrd_front.sv]
`default_nettype none
module rrd_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        en,
  input  wire logic                        in_valid,
  input  wire rrd_pkg::vec_t               in_d,
  input  wire rrd_pkg::vec_t               in_n,
  input  wire logic [15:0]                 in_ratio,
  output logic                             out_valid,
  output rrd_pkg::carry_t                  out_carry,
  output logic [rrd_pkg::DiffW-1:0]        out_diff
);

  logic [rrd_pkg::FrontStages-1:0] v_r;

  rrd_pkg::vec_t a_d_r, a_n_r, b_d_r, b_n_r, c_d_r, c_n_r, d_d_r, d_n_r;
  rrd_pkg::vec_t e_n_r, f_n_r, g_n_r, h_n_r, i_n_r;
  logic [15:0] a_ra_r, b_ra_r, c_ra_r, d_ra_r, e_ra_r;

  logic signed [31:0] b_dn_r [3];
  logic signed [33:0] c_c_r;
  logic signed [49:0] d_cn_r [3];
  logic signed [35:0] e_t_r  [3];
  logic signed [52:0] f_pr_r [3];
  logic signed [rrd_pkg::PW-1:0] g_p_r [3];
  logic signed [rrd_pkg::PW-1:0] h_p_r [3];
  logic signed [rrd_pkg::PW-1:0] i_p_r [3];
  logic signed [51:0] h_sq_r [3];
  logic [rrd_pkg::DiffW-1:0] i_diff_r;

  logic signed [33:0] dot_sum;
  logic signed [33:0] c_nxt;
  logic signed [50:0] len_sum;
  logic signed [50:0] diff_s;

  always_comb begin
    dot_sum = 34'(b_dn_r[0]) + 34'(b_dn_r[1]) + 34'(b_dn_r[2]);
    c_nxt   = -dot_sum;
    // The cosine is clamped from above only.
    if (c_nxt > rrd_pkg::OneQ28) begin
      c_nxt = rrd_pkg::OneQ28;
    end
    len_sum = 51'(h_sq_r[0]) + 51'(h_sq_r[1]) + 51'(h_sq_r[2]);
    diff_s  = 51'(rrd_pkg::OneQ28) - len_sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[rrd_pkg::FrontStages-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_d_r <= in_d;  a_n_r <= in_n;  a_ra_r <= in_ratio;
      b_d_r <= a_d_r; b_n_r <= a_n_r; b_ra_r <= a_ra_r;
      c_d_r <= b_d_r; c_n_r <= b_n_r; c_ra_r <= b_ra_r;
      d_d_r <= c_d_r; d_n_r <= c_n_r; d_ra_r <= c_ra_r;
      e_n_r <= d_n_r; e_ra_r <= d_ra_r;
      f_n_r <= e_n_r; g_n_r <= f_n_r; h_n_r <= g_n_r; i_n_r <= h_n_r;
      c_c_r <= c_nxt;
      for (int i = 0; i < 3; i++) begin
        b_dn_r[i] <= $signed(a_d_r[i]) * $signed(a_n_r[i]);
        d_cn_r[i] <= 50'(c_c_r * $signed(c_n_r[i]));
        e_t_r[i]  <= 36'(($signed({{6{d_d_r[i][15]}}, d_d_r[i], 28'd0}) + d_cn_r[i]
                         + 50'sd8192) >>> 14);
        f_pr_r[i] <= 53'($signed({1'b0, e_ra_r}) * e_t_r[i]);
        g_p_r[i]  <= rrd_pkg::PW'((f_pr_r[i] + 53'sd33554432) >>> 26);
        h_p_r[i]  <= g_p_r[i];
        h_sq_r[i] <= 52'(g_p_r[i] * g_p_r[i]);
        i_p_r[i]  <= h_p_r[i];
      end
      i_diff_r <= diff_s[50] ? rrd_pkg::DiffW'(-diff_s) : rrd_pkg::DiffW'(diff_s);
    end
  end

  always_comb begin
    out_valid   = v_r[rrd_pkg::FrontStages-1];
    out_carry.n = i_n_r;
    for (int i = 0; i < 3; i++) begin
      out_carry.p[i] = i_p_r[i];
    end
    out_diff = i_diff_r;
  end

endmodule
`default_nettype wire

[sv/rrd_sqrt.sv]
`default_nettype none
module rrd_sqrt (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire logic                          in_valid,
  input  wire logic [rrd_pkg::DiffW-1:0]     in_rad,
  input  wire rrd_pkg::carry_t               in_carry,
  output logic                               out_valid,
  output logic [rrd_pkg::RootW-1:0]          out_root,
  output logic [rrd_pkg::DiffW-1:0]          out_rem,
  output rrd_pkg::carry_t                    out_carry
);

  localparam int RW = rrd_pkg::RootW;
  localparam int AW = rrd_pkg::DiffW;

  logic                v_r     [RW+1];
  logic [AW-1:0]       rem_r   [RW+1];
  logic [RW-1:0]       root_r  [RW+1];
  rrd_pkg::carry_t     carry_r [RW+1];

  always_comb begin
    v_r[0]     = in_valid;
    rem_r[0]   = in_rad;
    root_r[0]  = '0;
    carry_r[0] = in_carry;
  end

  // One result bit per stage, most significant first; rem stays radicand minus root squared.
  for (genvar k = 0; k < RW; k++) begin : g_step
    localparam int B = RW - 1 - k;
    logic [AW-1:0] trial;
    logic          take;

    always_comb begin
      trial = (AW'(root_r[k]) << (B + 1)) | (AW'(1) << (2 * B));
      take  = rem_r[k] >= trial;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1]   <= take ? rem_r[k] - trial : rem_r[k];
        root_r[k+1]  <= take ? (root_r[k] | (RW'(1) << B)) : root_r[k];
        carry_r[k+1] <= carry_r[k];
      end
    end
  end

  always_comb begin
    out_valid = v_r[RW];
    out_root  = root_r[RW];
    out_rem   = rem_r[RW];
    out_carry = carry_r[RW];
  end

endmodule
`default_nettype wire

[sv/rrd_back.sv]
`default_nettype none
module rrd_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire logic                          in_valid,
  input  wire logic [rrd_pkg::RootW-1:0]     in_root,
  input  wire logic [rrd_pkg::DiffW-1:0]     in_rem,
  input  wire rrd_pkg::carry_t               in_carry,
  output logic                               out_valid,
  output logic signed [rrd_pkg::OutW-1:0]    out_x,
  output logic signed [rrd_pkg::OutW-1:0]    out_y,
  output logic signed [rrd_pkg::OutW-1:0]    out_z,
  output logic                               out_clip
);

  localparam int SW = rrd_pkg::RootW + 1;

  logic [2:0] v_r;
  logic [SW-1:0] r_s_r;
  rrd_pkg::carry_t r_c_r, m_c_r;
  logic signed [SW+16:0] m_sn_r [3];
  logic signed [rrd_pkg::OutW-1:0] o_r_r [3];
  logic o_clip_r;

  logic signed [SW+17:0] q_v [3];
  logic signed [31:0]    sum_v [3];
  logic signed [rrd_pkg::OutW-1:0] sat_v [3];
  logic [2:0] clip_v;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q_v[i]   = (-(SW+18)'(m_sn_r[i]) + (SW+18)'(8192)) >>> 14;
      sum_v[i] = 32'($signed(m_c_r.p[i])) + 32'(q_v[i]);
      clip_v[i] = 1'b1;
      if (sum_v[i] > rrd_pkg::OutMax) begin
        sat_v[i] = rrd_pkg::OutW'(rrd_pkg::OutMax);
      end else if (sum_v[i] < rrd_pkg::OutMin) begin
        sat_v[i] = rrd_pkg::OutW'(rrd_pkg::OutMin);
      end else begin
        sat_v[i]  = rrd_pkg::OutW'(sum_v[i]);
        clip_v[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Round to nearest: bump the root when the remainder exceeds it.
      r_s_r <= SW'(in_root) + SW'(in_rem > rrd_pkg::DiffW'(in_root));
      r_c_r <= in_carry;
      m_c_r <= r_c_r;
      for (int i = 0; i < 3; i++) begin
        m_sn_r[i] <= (SW+17)'($signed({1'b0, r_s_r}) * $signed(r_c_r.n[i]));
        o_r_r[i]  <= sat_v[i];
      end
      o_clip_r <= |clip_v;
    end
  end

  always_comb begin
    out_valid = v_r[2];
    out_x     = o_r_r[0];
    out_y     = o_r_r[1];
    out_z     = o_r_r[2];
    out_clip  = o_clip_r;
  end

endmodule
`default_nettype wire

[sv/ray_refraction_direction.sv]
// Refracted ray direction, one ray per clock cycle when the output is taken.
// The pipeline runs from input accept to out_valid through 9 front stages for the
// dot product, refraction scale and length, 25 square root stages at one root
// bit each and 3 back stages for rounding, scaling by the normal and saturation.
// A stall on the output freezes the whole pipeline. Synchronous active-low
// reset clears all valid bits; payload registers are not reset.
`default_nettype none
module ray_refraction_direction (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] in_dir_x,
  input  wire logic signed [15:0] in_dir_y,
  input  wire logic signed [15:0] in_dir_z,
  input  wire logic signed [15:0] in_normal_x,
  input  wire logic signed [15:0] in_normal_y,
  input  wire logic signed [15:0] in_normal_z,
  input  wire logic [15:0]        in_index_ratio,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [21:0]      out_refr_x,
  output logic signed [21:0]      out_refr_y,
  output logic signed [21:0]      out_refr_z,
  output logic                    out_clipped
);

  logic en;
  rrd_pkg::vec_t d_v, n_v;
  logic f_valid, s_valid;
  rrd_pkg::carry_t f_carry, s_carry;
  logic [rrd_pkg::DiffW-1:0] f_diff, s_rem;
  logic [rrd_pkg::RootW-1:0] s_root;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;
  assign d_v = {in_dir_z, in_dir_y, in_dir_x};
  assign n_v = {in_normal_z, in_normal_y, in_normal_x};

  rrd_front u_front (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(in_valid && en), .in_d(d_v), .in_n(n_v), .in_ratio(in_index_ratio),
    .out_valid(f_valid), .out_carry(f_carry), .out_diff(f_diff)
  );

  rrd_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(f_valid), .in_rad(f_diff), .in_carry(f_carry),
    .out_valid(s_valid), .out_root(s_root), .out_rem(s_rem), .out_carry(s_carry)
  );

  rrd_back u_back (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(s_valid), .in_root(s_root), .in_rem(s_rem), .in_carry(s_carry),
    .out_valid(out_valid), .out_x(out_refr_x), .out_y(out_refr_y),
    .out_z(out_refr_z), .out_clip(out_clipped)
  );

endmodule
`default_nettype wire

[dv/testbench.sv]
`timescale 1ns / 100ps
module testbench;

  typedef struct {
    logic signed [15:0] dir_x, dir_y, dir_z;
    logic signed [15:0] nrm_x, nrm_y, nrm_z;
    logic [15:0]        ratio;
  } ray_req_t;

  typedef struct {
    logic signed [21:0] refr_x, refr_y, refr_z;
    logic               clipped;
  } refr_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] in_dir_x = '0, in_dir_y = '0, in_dir_z = '0;
  logic signed [15:0] in_normal_x = '0, in_normal_y = '0, in_normal_z = '0;
  logic [15:0] in_index_ratio = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [21:0] out_refr_x, out_refr_y, out_refr_z;
  logic out_clipped;

  ray_refraction_direction i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_dir_x(in_dir_x), .in_dir_y(in_dir_y), .in_dir_z(in_dir_z),
    .in_normal_x(in_normal_x), .in_normal_y(in_normal_y), .in_normal_z(in_normal_z),
    .in_index_ratio(in_index_ratio),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_refr_x(out_refr_x), .out_refr_y(out_refr_y), .out_refr_z(out_refr_z),
    .out_clipped(out_clipped)
  );

  ray_req_t pending_rays[$];
  refr_t    expected_refr[$];
  int  error_count = 0;
  int  accepted_rays = 0;
  int  checked_rays = 0;
  int  clipped_seen = 0;
  bit  idle_free = 1'b0;
  bit  sender_hold = 1'b0;
  bit  sink_hold_req = 1'b0;
  int  sink_hold_left = 0;

  // Set at the rising edge when the offered request was taken.
  bit in_ready_seen = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Round v / 2^s to nearest with ties toward positive infinity.
  function automatic longint round_shr(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint isqrt_nearest(longint a);
    longint lo, hi, mid;
    lo = 0;
    hi = 64'sd2147483647;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (mid * mid <= a) lo = mid;
      else hi = mid - 1;
    end
    if (a - lo * lo > lo) lo = lo + 1;
    return lo;
  endfunction

  function automatic refr_t refract_ray(ray_req_t r);
    longint d[3], n[3], p[3], res[3];
    longint cosv, len, diff, root, t28;
    refr_t o;
    d[0] = r.dir_x; d[1] = r.dir_y; d[2] = r.dir_z;
    n[0] = r.nrm_x; n[1] = r.nrm_y; n[2] = r.nrm_z;
    cosv = -(d[0] * n[0] + d[1] * n[1] + d[2] * n[2]);
    if (cosv > 64'sd268435456) cosv = 64'sd268435456;
    len = 0;
    for (int i = 0; i < 3; i++) begin
      t28 = round_shr(d[i] * 64'sd268435456 + cosv * n[i], 14);
      p[i] = round_shr(longint'(r.ratio) * t28, 26);
      len += p[i] * p[i];
    end
    diff = 64'sd268435456 - len;
    if (diff < 0) diff = -diff;
    root = isqrt_nearest(diff);
    o.clipped = 1'b0;
    for (int i = 0; i < 3; i++) begin
      res[i] = p[i] + round_shr(-(root * n[i]), 14);
      if (res[i] > 64'sd2097151) begin
        res[i] = 64'sd2097151;
        o.clipped = 1'b1;
      end else if (res[i] < -64'sd2097152) begin
        res[i] = -64'sd2097152;
        o.clipped = 1'b1;
      end
    end
    o.refr_x = res[0][21:0];
    o.refr_y = res[1][21:0];
    o.refr_z = res[2][21:0];
    return o;
  endfunction

  function automatic ray_req_t make_ray(int dx, int dy, int dz, int nx, int ny, int nz,
                                        int ratio);
    ray_req_t r;
    r.dir_x = 16'(dx); r.dir_y = 16'(dy); r.dir_z = 16'(dz);
    r.nrm_x = 16'(nx); r.nrm_y = 16'(ny); r.nrm_z = 16'(nz);
    r.ratio = 16'(ratio);
    return r;
  endfunction

  // Random direction and normal components in -16384..16383, fully random in one case of five.
  function automatic ray_req_t random_hit();
    ray_req_t r;
    int sel;
    r.dir_x = 16'($urandom_range(32767, 0) - 16384);
    r.dir_y = 16'($urandom_range(32767, 0) - 16384);
    r.dir_z = 16'($urandom_range(32767, 0) - 16384);
    r.nrm_x = 16'($urandom_range(32767, 0) - 16384);
    r.nrm_y = 16'($urandom_range(32767, 0) - 16384);
    r.nrm_z = 16'($urandom_range(32767, 0) - 16384);
    sel = $urandom_range(9, 0);
    if (sel < 6) r.ratio = 16'($urandom_range(8192, 2048));
    else r.ratio = 16'($urandom());
    if ($urandom_range(4, 0) == 0) begin
      r.dir_x = 16'($urandom()); r.dir_y = 16'($urandom()); r.dir_z = 16'($urandom());
      r.nrm_x = 16'($urandom()); r.nrm_y = 16'($urandom()); r.nrm_z = 16'($urandom());
    end
    return r;
  endfunction

  // Driver: presents the next pending ray; payload and valid change on the falling edge.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_ready_seen) begin
        if (pending_rays.size() > 0 && !sender_hold &&
            (idle_free || $urandom_range(99, 0) >= 9)) begin
          in_valid <= 1'b1;
          in_dir_x <= pending_rays[0].dir_x;
          in_dir_y <= pending_rays[0].dir_y;
          in_dir_z <= pending_rays[0].dir_z;
          in_normal_x <= pending_rays[0].nrm_x;
          in_normal_y <= pending_rays[0].nrm_y;
          in_normal_z <= pending_rays[0].nrm_z;
          in_index_ratio <= pending_rays[0].ratio;
          void'(pending_rays.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random back-pressure plus one long hold counted here in cycles.
  always @(negedge clk) begin
    if (rst_n) begin
      if (sink_hold_req) begin
        sink_hold_left = 400;
        sink_hold_req = 1'b0;
      end
      if (sink_hold_left > 0) begin
        sink_hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= idle_free || $urandom_range(99, 0) >= 9;
      end
    end
  end

  // Monitor: captures accepted requests and checks accepted results.
  always @(posedge clk) begin
    ray_req_t req;
    refr_t want;
    in_ready_seen <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        req.dir_x = in_dir_x; req.dir_y = in_dir_y; req.dir_z = in_dir_z;
        req.nrm_x = in_normal_x; req.nrm_y = in_normal_y; req.nrm_z = in_normal_z;
        req.ratio = in_index_ratio;
        expected_refr.push_back(refract_ray(req));
        accepted_rays++;
      end
      if (out_valid && out_ready) begin
        if (expected_refr.size() == 0) begin
          $error("result with no request outstanding");
          error_count++;
        end else begin
          want = expected_refr.pop_front();
          checked_rays++;
          if (out_clipped) clipped_seen++;
          if (out_refr_x !== want.refr_x) begin
            $error("refr_x expected %0d got %0d", want.refr_x, out_refr_x);
            error_count++;
          end
          if (out_refr_y !== want.refr_y) begin
            $error("refr_y expected %0d got %0d", want.refr_y, out_refr_y);
            error_count++;
          end
          if (out_refr_z !== want.refr_z) begin
            $error("refr_z expected %0d got %0d", want.refr_z, out_refr_z);
            error_count++;
          end
          if (out_clipped !== want.clipped) begin
            $error("clipped expected %0d got %0d", want.clipped, out_clipped);
            error_count++;
          end
        end
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rays: head-on, grazing, extremes, zero ratio, clamped cosine, TIR.
    pending_rays.push_back(make_ray(0, 0, -16384, 0, 0, 16384, 4096));
    pending_rays.push_back(make_ray(16384, 0, 0, 0, 0, 16384, 4096));
    pending_rays.push_back(make_ray(11585, 0, -11585, 0, 0, 16384, 6144));
    pending_rays.push_back(make_ray(11585, 0, -11585, 0, 0, 16384, 2731));
    pending_rays.push_back(make_ray(14189, 0, -8192, 0, 0, 16384, 8192));
    pending_rays.push_back(make_ray(0, 0, -16384, 0, 0, 16384, 0));
    pending_rays.push_back(make_ray(1000, -2000, 300, 0, 16384, 0, 0));
    pending_rays.push_back(make_ray(0, 0, -32768, 0, 0, 32767, 4096));
    pending_rays.push_back(make_ray(-32768, -32768, -32768, 32767, 32767, 32767, 65535));
    pending_rays.push_back(make_ray(32767, 32767, 32767, -32768, -32768, -32768, 65535));
    pending_rays.push_back(make_ray(32767, -32768, 32767, -32768, 32767, -32768, 65535));
    pending_rays.push_back(make_ray(-32768, 32767, -32768, 32767, -32768, 32767, 65535));
    pending_rays.push_back(make_ray(32767, 32767, 32767, 32767, 32767, 32767, 65535));
    pending_rays.push_back(make_ray(0, 0, 0, 0, 0, 0, 65535));
    pending_rays.push_back(make_ray(-1, -1, -1, -1, -1, -1, 1));
    pending_rays.push_back(make_ray(0, 0, 16384, 0, 0, 16384, 4096));
    pending_rays.push_back(make_ray(5461, 5461, 5461, 9459, 9459, 9459, 12288));
    pending_rays.push_back(make_ray(21845, -10922, 0, 0, 32767, 0, 43690));

    // Long output stall while the sender keeps offering, then random rays.
    for (int i = 0; i < 150; i++) pending_rays.push_back(random_hit());
    repeat (20) @(posedge clk);
    sink_hold_req = 1'b1;
    wait (pending_rays.size() == 0);

    // Sender pauses until the pipeline drains.
    sender_hold = 1'b1;
    wait (expected_refr.size() == 0 && !in_valid);
    sender_hold = 1'b0;

    idle_free = 1'b1;
    for (int i = 0; i < 200; i++) pending_rays.push_back(random_hit());
    wait (pending_rays.size() == 0);
    idle_free = 1'b0;
    for (int i = 0; i < 300; i++) pending_rays.push_back(random_hit());
    wait (pending_rays.size() == 0);
    @(posedge clk);
    wait (!in_valid);
    wait (expected_refr.size() == 0);
    repeat (60) @(posedge clk);

    $display("Ran %0d rays (%0d checked, %0d saturated)", accepted_rays, checked_rays,
             clipped_seen);
    $display("through directed, long-stall, drain and random phases.");
    if (error_count == 0 && expected_refr.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
